// ===== rtl/core/tcpt_pkg.sv =====
// Shared types and constants for the terminal column pad tracker.
// Used by terminal_column_pad_tracker_core; depends on nothing else.
package tcpt_pkg;

    // Sequencer states of the core.
    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_DIV = 2'd1,
        ST_FIN = 2'd2,
        ST_OUT = 2'd3
    } t_state;

    // Escape tracking modes.
    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_SAW    = 2'd1,
        ESC_CSI    = 2'd2
    } t_esc_mode;

    localparam int WIDTH_BITS    = 12;
    localparam int APB_ADDR_BITS = 3;

    // Register index of the line width register in the register map.
    localparam logic REG_LINE_WIDTH = 1'b0;

    localparam logic [WIDTH_BITS-1:0] DEFAULT_WIDTH = 12'd80;

    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_CSI_OPEN  = 8'h5B;
    localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_TAB       = 8'h09;

endpackage

// ===== rtl/core/terminal_column_pad_tracker_core.sv =====
// Top level of the terminal column pad tracker: escape stripping, column tracking
// and the right-alignment padding computed by a bit-serial restoring-divide unit.
// Depends on tcpt_pkg.
//
// Usage: message bytes enter one word per cycle on the s_axis channel while the core
// is not busy with a finished message (tdata[7:0] is the byte, tlast marks the final
// byte of a message). ANSI CSI escapes are removed and the cursor column of the
// visible text is tracked. After the last byte no new word is accepted until the
// result is taken: COLUMN_BITS one-bit-per-cycle remainder steps reduce the column
// modulo the terminal width, a further step forms the padding, and the result word
// is then held on m_axis. The result word carries the pad count in tdata[11:0] and
// the wrap flag in tuser. It stays until m_axis_tready is high; while it waits, no
// new byte is accepted. After the result the column and escape mode start fresh.
// Reset (synchronous, active low) clears the column and escape mode and loads the
// line width register with 80. The APB port holds that register at byte address 0;
// a zero width means 80 columns. Write it only while no message is in flight.
module terminal_column_pad_tracker_core #(
    parameter int TAB_STOP    = 8,
    parameter int MARK_WIDTH  = 2,
    parameter int COLUMN_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input byte stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] char_byte
    input  logic                              s_axis_tlast,  // is_last
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [11:0] pad_count, rest zero
    output logic                              m_axis_tuser,  // [0] wrap_first
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcpt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int WB     = tcpt_pkg::WIDTH_BITS;
    localparam int PH_W   = $clog2(TAB_STOP);
    localparam int CNT_W  = $clog2(COLUMN_BITS);
    localparam logic [PH_W-1:0]        PH_LAST  = PH_W'(TAB_STOP - 1);
    localparam logic [COLUMN_BITS:0]   TAB_EXT  = (COLUMN_BITS+1)'(TAB_STOP);
    localparam logic [CNT_W-1:0]       CNT_LAST = CNT_W'(COLUMN_BITS - 1);
    localparam logic [WB:0]            MARK_EXT = (WB+1)'(MARK_WIDTH);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [WB-1:0] r_line_width;
    logic [WB-1:0] w_eff;
    logic          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == tcpt_pkg::REG_LINE_WIDTH);
    assign prdata  = cfg_sel ? {{(32-WB){1'b0}}, r_line_width} : 32'd0;
    assign w_eff   = (r_line_width == '0) ? tcpt_pkg::DEFAULT_WIDTH : r_line_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= tcpt_pkg::DEFAULT_WIDTH;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_line_width <= pwdata[WB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    tcpt_pkg::t_state    r_state, n_state;
    tcpt_pkg::t_esc_mode r_esc, n_esc;
    logic [COLUMN_BITS-1:0] r_column, n_column;   // doubles as dividend shift register
    logic [PH_W-1:0]        r_phase, n_phase;     // column modulo the tab stop
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [WB-1:0]          r_rem, n_rem;
    logic [WB-1:0]          r_pad, n_pad;
    logic                   r_wrap, n_wrap;

    logic s_accept;
    logic m_accept;

    // Output decode of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            tcpt_pkg::ST_RUN: s_axis_tready = 1'b1;
            tcpt_pkg::ST_OUT: m_axis_tvalid = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign s_accept     = s_axis_tvalid && s_axis_tready;
    assign m_accept     = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {{(16-WB){1'b0}}, r_pad};
    assign m_axis_tuser = r_wrap;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcpt_pkg::ST_RUN: if (s_accept && s_axis_tlast) n_state = tcpt_pkg::ST_DIV;
            tcpt_pkg::ST_DIV: if (r_cnt == '0) n_state = tcpt_pkg::ST_FIN;
            tcpt_pkg::ST_FIN: n_state = tcpt_pkg::ST_OUT;
            tcpt_pkg::ST_OUT: if (m_accept) n_state = tcpt_pkg::ST_RUN;
            default: n_state = tcpt_pkg::ST_RUN;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte handling: escape filter and column advance.
    // ------------------------------------------------------------------
    logic                 visible;
    logic [COLUMN_BITS:0] col_sum;
    logic [COLUMN_BITS:0] col_inc;
    logic                 is_tab;
    logic                 is_break;

    assign is_tab   = (s_axis_tdata == tcpt_pkg::BYTE_TAB);
    assign is_break = (s_axis_tdata == tcpt_pkg::BYTE_LF) ||
                      (s_axis_tdata == tcpt_pkg::BYTE_CR);
    assign col_inc  = is_tab ? (TAB_EXT - (COLUMN_BITS+1)'(r_phase)) : (COLUMN_BITS+1)'(1);
    assign col_sum  = {1'b0, r_column} + col_inc;

    // One restoring-divide step: shift in the next column bit, subtract if it fits.
    logic [WB:0] trial;
    assign trial = {r_rem, r_column[COLUMN_BITS-1]};

    // Padding formation from the remainder.
    logic [WB:0] rem_mark;
    assign rem_mark = {1'b0, r_rem} + MARK_EXT;

    always_comb begin
        n_esc    = r_esc;
        n_column = r_column;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_pad    = r_pad;
        n_wrap   = r_wrap;
        visible  = 1'b0;

        case (r_state)
            tcpt_pkg::ST_RUN: begin
                if (s_accept) begin
                    case (r_esc)
                        tcpt_pkg::ESC_CSI: begin
                            if (s_axis_tdata >= tcpt_pkg::BYTE_FINAL_LO &&
                                s_axis_tdata <= tcpt_pkg::BYTE_FINAL_HI) begin
                                n_esc = tcpt_pkg::ESC_NORMAL;
                            end
                        end
                        tcpt_pkg::ESC_SAW: begin
                            if (s_axis_tdata == tcpt_pkg::BYTE_CSI_OPEN) begin
                                n_esc = tcpt_pkg::ESC_CSI;
                            end else if (s_axis_tdata == tcpt_pkg::BYTE_ESC) begin
                                n_esc = tcpt_pkg::ESC_SAW;
                            end else begin
                                n_esc   = tcpt_pkg::ESC_NORMAL;
                                visible = 1'b1;
                            end
                        end
                        default: begin
                            if (s_axis_tdata == tcpt_pkg::BYTE_ESC) begin
                                n_esc = tcpt_pkg::ESC_SAW;
                            end else begin
                                n_esc   = tcpt_pkg::ESC_NORMAL;
                                visible = 1'b1;
                            end
                        end
                    endcase

                    if (visible) begin
                        if (is_break) begin
                            n_column = '0;
                            n_phase  = '0;
                        end else begin
                            // Once the column saturates it stays put, so the tab
                            // phase no longer matters until the next line break.
                            n_column = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
                            if (is_tab || r_phase == PH_LAST) begin
                                n_phase = '0;
                            end else begin
                                n_phase = r_phase + PH_W'(1);
                            end
                        end
                    end

                    if (s_axis_tlast) begin
                        // The message ends: escape state is discarded and the
                        // column is consumed by the remainder steps.
                        n_esc   = tcpt_pkg::ESC_NORMAL;
                        n_phase = '0;
                        n_rem   = '0;
                        n_cnt   = CNT_LAST;
                    end
                end
            end
            tcpt_pkg::ST_DIV: begin
                if (trial >= {1'b0, w_eff}) begin
                    n_rem = WB'(trial - {1'b0, w_eff});
                end else begin
                    n_rem = trial[WB-1:0];
                end
                // Shifting in zeros leaves the column cleared for the next message.
                n_column = {r_column[COLUMN_BITS-2:0], 1'b0};
                n_cnt    = r_cnt - CNT_W'(1);
            end
            tcpt_pkg::ST_FIN: begin
                if ({1'b0, w_eff} > rem_mark) begin
                    n_pad  = WB'({1'b0, w_eff} - rem_mark);
                    n_wrap = 1'b0;
                end else begin
                    n_pad  = ({1'b0, w_eff} > MARK_EXT) ? WB'({1'b0, w_eff} - MARK_EXT) : '0;
                    n_wrap = 1'b1;
                end
            end
            default: begin
                n_esc = r_esc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcpt_pkg::ST_RUN;
            r_esc    <= tcpt_pkg::ESC_NORMAL;
            r_column <= '0;
            r_phase  <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_esc    <= n_esc;
            r_column <= n_column;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_pad  <= n_pad;
        r_wrap <= n_wrap;
    end

endmodule

// ===== tb/tb_terminal_column_pad_tracker_core.sv =====
// Self-checking testbench for terminal_column_pad_tracker_core: streams messages,
// predicts the padding result of each one and compares it with the result stream.
// Depends on tcpt_pkg and the core RTL only.
module tb_terminal_column_pad_tracker_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_STOP    = 8;
    localparam int MARK_WIDTH  = 2;
    localparam int COLUMN_BITS = 16;

    localparam int WB        = tcpt_pkg::WIDTH_BITS;
    localparam int ADDR_BITS = tcpt_pkg::APB_ADDR_BITS;

    localparam int CLK_PERIOD  = 10;
    // This limit leaves ample margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Random words per configuration phase; eight phases give about 1400 words.
    localparam int PHASE_WORDS = 175;
    // Idle time that drain_results adds once every result has come back.
    localparam int SETTLE_CYCLES = COLUMN_BITS + 4;

    localparam longint unsigned COLUMN_MAX = (64'd1 << COLUMN_BITS) - 64'd1;
    localparam logic [ADDR_BITS-1:0] WIDTH_ADDR = ADDR_BITS'(tcpt_pkg::REG_LINE_WIDTH) << 2;

    // One input word: a text byte and the end-of-message flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_word;

    // One expected padding result.
    typedef struct packed {
        logic [WB-1:0] pad;
        logic          wrap;
    } t_pad_result;

    // Every input of the core starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;  // [7:0] char_byte
    logic        s_axis_tlast  = 1'b0;  // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;  // [11:0] pad_count, rest zero
    logic        m_axis_tuser;  // [0] wrap_first
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus waiting for the driver and results waiting for the checker.
    t_text_word  text_words[$];
    t_pad_result pad_results[$];

    // Shadow of the core's state and of its line width register.
    tcpt_pkg::t_esc_mode    scan_mode     = tcpt_pkg::ESC_NORMAL;
    logic [COLUMN_BITS-1:0] shadow_column = '0;
    logic [WB-1:0]          width_shadow  = tcpt_pkg::DEFAULT_WIDTH;

    // Handshake flags seen at the last rising edge, read by the falling-edge drivers.
    logic byte_taken   = 1'b0;
    logic result_taken = 1'b0;

    // Idle limits for the current phase; zero means the side never idles.
    int unsigned send_gap_max    = 0;
    int unsigned recv_gap_max    = 0;
    int unsigned send_gap_left   = 0;
    int unsigned recv_stall_left = 0;

    int unsigned bytes_queued    = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned messages_queued = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    terminal_column_pad_tracker_core #(
        .TAB_STOP    (TAB_STOP),
        .MARK_WIDTH  (MARK_WIDTH),
        .COLUMN_BITS (COLUMN_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Runs one accepted byte through the shadow state. A byte marked last also
    // yields the padding for the message and clears the state for the next one.
    task automatic track_byte(input logic [7:0] ch, input logic last);
        longint unsigned next_col;
        longint unsigned w;
        longint unsigned c;
        t_pad_result     r;
        if (scan_mode == tcpt_pkg::ESC_CSI) begin
            // Inside a CSI sequence only a final byte matters; it ends the escape.
            if (ch >= tcpt_pkg::BYTE_FINAL_LO && ch <= tcpt_pkg::BYTE_FINAL_HI) begin
                scan_mode = tcpt_pkg::ESC_NORMAL;
            end
        end else if (scan_mode == tcpt_pkg::ESC_SAW && ch == tcpt_pkg::BYTE_CSI_OPEN) begin
            scan_mode = tcpt_pkg::ESC_CSI;
        end else if (ch == tcpt_pkg::BYTE_ESC) begin
            // A pending ESC followed by another ESC drops the first one.
            scan_mode = tcpt_pkg::ESC_SAW;
        end else begin
            // Visible text, including the byte after a lone ESC.
            scan_mode = tcpt_pkg::ESC_NORMAL;
            if (ch == tcpt_pkg::BYTE_LF || ch == tcpt_pkg::BYTE_CR) begin
                shadow_column = '0;
            end else begin
                if (ch == tcpt_pkg::BYTE_TAB) begin
                    next_col = longint'(shadow_column) + TAB_STOP
                               - longint'(shadow_column) % TAB_STOP;
                end else begin
                    next_col = longint'(shadow_column) + 1;
                end
                shadow_column = (next_col > COLUMN_MAX) ? COLUMN_MAX[COLUMN_BITS-1:0]
                                                        : next_col[COLUMN_BITS-1:0];
            end
        end

        if (last) begin
            w = (width_shadow == '0) ? longint'(tcpt_pkg::DEFAULT_WIDTH)
                                     : longint'(width_shadow);
            c = longint'(shadow_column) % w;
            if (w > c + MARK_WIDTH) begin
                r.pad  = WB'(w - c - MARK_WIDTH);
                r.wrap = 1'b0;
            end else begin
                // The marker does not fit on this line: wrap and pad a full line less the marker.
                r.pad  = (w > MARK_WIDTH) ? WB'(w - MARK_WIDTH) : '0;
                r.wrap = 1'b1;
            end
            pad_results.insert(pad_results.size(), r);
            scan_mode     = tcpt_pkg::ESC_NORMAL;
            shadow_column = '0;
        end
    endtask

    // Sampling at the rising edge: count accepted words, predict, and check results.
    always @(posedge i_clk) begin : sample_edges
        t_pad_result want;
        cycle_count++;
        byte_taken   <= s_axis_tvalid && s_axis_tready;
        result_taken <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bytes_accepted++;
            track_byte(s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pad_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: tdata=%0d tuser=%0b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = pad_results.pop_front();
                if (m_axis_tdata !== 16'(want.pad)) begin
                    report_mismatch($sformatf("pad_count %0d, expected %0d",
                                              m_axis_tdata, want.pad));
                end
                if (m_axis_tuser !== want.wrap) begin
                    report_mismatch($sformatf("wrap_first %0b, expected %0b",
                                              m_axis_tuser, want.wrap));
                end
                results_checked++;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results still expected",
                     cycle_count, pad_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Byte driver. A word on the bus is held until taken; before each new word the
    // driver idles for a number of cycles drawn when the previous word went out.
    always @(negedge i_clk) begin : drive_text
        t_text_word w;
        if (s_axis_tvalid && !byte_taken) begin
            // Still waiting for the core to take the current word.
        end else if (send_gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            send_gap_left--;
        end else if (text_words.size() > 0) begin
            w = text_words.pop_front();
            s_axis_tdata  <= w.ch;
            s_axis_tlast  <= w.last;
            s_axis_tvalid <= 1'b1;
            send_gap_left = $urandom_range(0, send_gap_max);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver. After each taken result it draws a stall that holds tready
    // low for that many cycles of a shown result, so a result waits a varied time.
    always @(negedge i_clk) begin
        if (result_taken) begin
            recv_stall_left = $urandom_range(0, recv_gap_max);
        end
        if (recv_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            if (m_axis_tvalid) begin
                recv_stall_left--;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_text(input logic [7:0] ch, input logic last);
        t_text_word tw;
        tw.ch   = ch;
        tw.last = last;
        text_words.insert(text_words.size(), tw);
        bytes_queued++;
        if (last) begin
            messages_queued++;
        end
    endtask

    // Queues the characters of s; the final one closes the message when ends is set.
    task automatic push_string(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++) begin
            push_text(s[i], ends && (i == s.len() - 1));
        end
    endtask

    // One random message built from tokens: plain text, tabs, line breaks, complete
    // or cut-off CSI sequences, lone and doubled ESC, and arbitrary bytes.
    task automatic queue_random_message(input int unsigned max_tokens);
        int unsigned n;
        int unsigned p;
        n = $urandom_range(0, max_tokens);
        repeat (n) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5, 6: push_text(8'($urandom_range(32, 126)), 1'b0);
                7: push_text(tcpt_pkg::BYTE_TAB, 1'b0);
                8: push_text($urandom_range(0, 1) ? tcpt_pkg::BYTE_LF : tcpt_pkg::BYTE_CR,
                             1'b0);
                9, 10: begin
                    push_text(tcpt_pkg::BYTE_ESC, 1'b0);
                    push_text(tcpt_pkg::BYTE_CSI_OPEN, 1'b0);
                    p = $urandom_range(0, 3);
                    repeat (p) push_text(8'($urandom_range(8'h30, 8'h3F)), 1'b0);
                    // Now and then the final byte is left out, so text runs on in CSI.
                    if ($urandom_range(0, 7) != 0) begin
                        push_text(8'($urandom_range(tcpt_pkg::BYTE_FINAL_LO,
                                                    tcpt_pkg::BYTE_FINAL_HI)), 1'b0);
                    end
                end
                11: begin
                    push_text(tcpt_pkg::BYTE_ESC, 1'b0);
                    push_text(8'($urandom_range(0, 255)), 1'b0);
                end
                12: begin
                    push_text(tcpt_pkg::BYTE_ESC, 1'b0);
                    push_text(tcpt_pkg::BYTE_ESC, 1'b0);
                end
                default: push_text(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            push_text(tcpt_pkg::BYTE_ESC, 1'b1);
        end else begin
            push_text(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Writes the line width register over APB, then reads it back.
    task automatic write_line_width(input logic [WB-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= WIDTH_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        width_shadow = value;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            report_mismatch($sformatf("line width read back %0d, wrote %0d", prdata, value));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued word is taken and every result has come back, then
    // idles for SETTLE_CYCLES more before the bus is touched again.
    task automatic drain_results();
        while (bytes_accepted != bytes_queued || pad_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [WB-1:0] width, input int unsigned send_max,
                             input int unsigned recv_max, input int unsigned max_tokens);
        int unsigned first;
        write_line_width(width);
        send_gap_max = send_max;
        recv_gap_max = recv_max;
        first = bytes_queued;
        while (bytes_queued - first < PHASE_WORDS) begin
            queue_random_message(max_tokens);
        end
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed messages at the reset width of 80 columns.
        send_gap_max = 3;
        recv_gap_max = 3;
        push_text(8'hFF, 1'b1);                          // top byte value alone
        push_text(tcpt_pkg::BYTE_TAB, 1'b0);             // tab stops around a byte
        push_string("x", 1'b0);
        push_text(tcpt_pkg::BYTE_TAB, 1'b1);
        push_string("ab", 1'b0);                         // newline restarts the column
        push_text(tcpt_pkg::BYTE_LF, 1'b0);
        push_string("c", 1'b1);
        push_string("a", 1'b0);                          // carriage return as last byte
        push_text(tcpt_pkg::BYTE_CR, 1'b1);
        push_text(tcpt_pkg::BYTE_ESC, 1'b0);             // CSI with the lowest final
        push_text(tcpt_pkg::BYTE_CSI_OPEN, 1'b0);
        push_text(tcpt_pkg::BYTE_FINAL_LO, 1'b0);
        push_string("z", 1'b1);
        push_text(tcpt_pkg::BYTE_ESC, 1'b1);             // ESC pending at the end
        push_text(tcpt_pkg::BYTE_ESC, 1'b0);             // message ends inside a CSI
        push_text(tcpt_pkg::BYTE_CSI_OPEN, 1'b0);
        push_string("1", 1'b1);
        push_text(tcpt_pkg::BYTE_ESC, 1'b0);             // ESC then ESC, top final
        push_text(tcpt_pkg::BYTE_ESC, 1'b0);
        push_text(tcpt_pkg::BYTE_CSI_OPEN, 1'b0);
        push_text(tcpt_pkg::BYTE_FINAL_HI, 1'b0);
        push_string("q", 1'b1);
        push_text(tcpt_pkg::BYTE_ESC, 1'b0);             // lone ESC before a byte
        push_string("x", 1'b1);
        drain_results();

        // Random phases over the width range, with varied idling on both sides.
        run_phase(12'd0,    18, 0,  40);
        run_phase(12'd1,    0,  18, 40);
        run_phase(12'd2,    5,  18, 40);
        run_phase(12'd3,    18, 5,  40);
        run_phase(12'd4095, 3,  3,  60);
        run_phase(12'd7,    0,  0,  40);
        run_phase(WB'($urandom_range(4, 200)), 18, 18, 60);
        run_phase(tcpt_pkg::DEFAULT_WIDTH, 9, 2, 90);

        foreach (pad_results[i]) begin
            report_mismatch($sformatf("result never arrived: pad=%0d wrap=%0b",
                                      pad_results[i].pad, pad_results[i].wrap));
        end

        $display("tb: %0d words in %0d messages sent, %0d padding results checked",
                 bytes_queued, messages_queued, results_checked);
        $display("tb: widths 0 through 3, 7, 80, 4095 and one random, with escapes and tabs");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
